// ----- rtl/core/sacd_pkg.sv -----
// ---------------------------------------------------------------------------
// sacd_pkg
// Shared types and constants for the set-associative cache directory.
// ---------------------------------------------------------------------------
`default_nettype none

package sacd_pkg;

   localparam int SETS       = 64;
   localparam int WAYS       = 4;
   localparam int LINE_BYTES = 64;
   localparam int ADDR_BITS  = 32;
   localparam int COUNT_BITS = 16;

   localparam int OFF_BITS  = $clog2(LINE_BYTES);
   localparam int SET_BITS  = $clog2(SETS);
   localparam int TAG_BITS  = ADDR_BITS - OFF_BITS - SET_BITS;
   localparam int WAY_BITS  = $clog2(WAYS);
   localparam int TREE_BITS = WAYS - 1;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   typedef enum logic [2:0] {
      FUNC_LOOKUP  = 3'd0,
      FUNC_PROBE   = 3'd1,
      FUNC_WRITE   = 3'd2,
      FUNC_WCOUNT  = 3'd3,
      FUNC_INSERT  = 3'd4,
      FUNC_REFRESH = 3'd5
   } func_type;

   localparam logic [2:0] POL_FIRST = 3'd0;
   localparam logic [2:0] POL_LFU   = 3'd1;
   localparam logic [2:0] POL_MFU   = 3'd2;
   localparam logic [2:0] POL_LRU   = 3'd3;
   localparam logic [2:0] POL_PLRU  = 3'd4;

   localparam logic [2:0] REG_POLICY = 3'd0;

   // one set's worth of directory state
   typedef struct packed {
      logic [WAYS-1:0]                     valid;
      logic [WAYS-1:0]                     dirty;
      logic [WAYS-1:0][TAG_BITS-1:0]       tag;
      logic [WAYS-1:0][COUNT_BITS-1:0]     count;
      logic [WAYS-1:0][WAY_BITS-1:0]       rank;
      logic [TREE_BITS-1:0]                tree;
   } set_type;

   typedef struct packed {
      logic                 hit;
      logic [WAY_BITS-1:0]  way;
      logic                 victim_valid;
      logic [ADDR_BITS-1:0] victim_address;
      logic                 victim_dirty;
   } result_type;

   function automatic set_type set_reset_value();
      set_type s;
      s = '0;
      for (int k = 0; k < WAYS; k++) begin
         s.rank[k] = WAY_BITS'(k);
      end
      return s;
   endfunction

   // update LRU ranks and PLRU tree for an access to way w
   function automatic set_type touch(set_type s, logic [WAY_BITS-1:0] w);
      set_type o;
      int unsigned node;
      int unsigned parent;
      o = s;
      for (int k = 0; k < WAYS; k++) begin
         if (s.rank[k] < s.rank[w]) begin
            o.rank[k] = s.rank[k] + 1'b1;
         end
      end
      o.rank[w] = '0;
      node = int'(w) + WAYS - 1;
      for (int l = 0; l < WAY_BITS; l++) begin
         parent = (node - 1) / 2;
         o.tree[parent] = node[0];
         node = parent;
      end
      return o;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/core/set_assoc_cache_directory.sv -----
// ---------------------------------------------------------------------------
// set_assoc_cache_directory
// Tag directory of a 64-set, 4-way cache with selectable replacement.
// ---------------------------------------------------------------------------
// Usage: request words (req_func, req_address, req_dirty_in) enter on the
// req_ channel; one response word per request leaves on rsp_ with hit, way
// and victim information. The replacement policy is set through the csr_
// APB port (register 0, reset LRU); the user writes it only while the block
// is idle, which the block itself does not enforce. Each request goes
// through the set memory: registered read in the cycle after acceptance,
// with update, write-back and response register load at the end of that
// cycle. A new request is not taken while one is in the set memory, as
// the single set memory does a read-modify-write.
// After reset the directory reads as empty (per-set written flags); no
// clearing pass is needed. When rsp_stall is high the response register
// holds and a new request is not taken until it drains.
// ---------------------------------------------------------------------------
`default_nettype none

module set_assoc_cache_directory
   import sacd_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [2:0]            req_func,
   input  wire logic [ADDR_BITS-1:0]  req_address,
   input  wire logic                  req_dirty_in,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic                       rsp_hit,
   output logic [WAY_BITS-1:0]        rsp_way,
   output logic                       rsp_victim_valid,
   output logic [ADDR_BITS-1:0]       rsp_victim_address,
   output logic                       rsp_victim_dirty,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [1:0]            csr_paddr,
   input  wire logic [31:0]           csr_pwdata,
   output logic [31:0]                csr_prdata,
   output logic                       csr_pready
);

   logic [2:0]            policy_ff;
   logic                  busy_ff;
   logic [2:0]            func_ff;
   logic [TAG_BITS-1:0]   tag_ff;
   logic [SET_BITS-1:0]   set_ff;
   logic                  dirty_ff;
   logic                  rsp_valid_ff;
   result_type            rsp_ff;
   set_type               cur;
   set_type               nxt;
   result_type            res;
   logic                  accept;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[1:0] == 2'(REG_POLICY)) ? {29'd0, policy_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff <= POL_LRU;
      end else if (csr_psel && csr_penable && csr_pwrite
                   && csr_paddr[1:0] == 2'(REG_POLICY)) begin
         policy_ff <= csr_pwdata[2:0];
      end
   end

   assign req_stall = busy_ff || (rsp_valid_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;

   sacd_set_ram u_ram (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept),
      .rd_set  (req_address[OFF_BITS +: SET_BITS]),
      .rd_data (cur),
      .wr_en   (busy_ff),
      .wr_set  (set_ff),
      .wr_data (nxt)
   );

   sacd_update u_upd (
      .cur      (cur),
      .func     (func_ff),
      .policy   (policy_ff),
      .tag      (tag_ff),
      .set_idx  (set_ff),
      .dirty_in (dirty_ff),
      .nxt      (nxt),
      .res      (res)
   );

   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff  <= req_func;
         tag_ff   <= req_address[ADDR_BITS-1 -: TAG_BITS];
         set_ff   <= req_address[OFF_BITS +: SET_BITS];
         dirty_ff <= req_dirty_in;
      end
      if (busy_ff) begin
         rsp_ff <= res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff <= accept;
         if (busy_ff) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_hit            = rsp_ff.hit;
   assign rsp_way            = rsp_ff.way;
   assign rsp_victim_valid   = rsp_ff.victim_valid;
   assign rsp_victim_address = rsp_ff.victim_address;
   assign rsp_victim_dirty   = rsp_ff.victim_dirty;

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !(rsp_valid_ff && rsp_stall && $past(rsp_valid_ff)))
      else $error("response overwritten");
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      busy_ff |=> !busy_ff)
      else $error("two requests in flight");
   a_victim_on_insert: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && res.victim_valid) |-> (func_ff == FUNC_INSERT))
      else $error("victim outside insert");

endmodule

`default_nettype wire

// ----- rtl/core/sacd_set_ram.sv -----
// ---------------------------------------------------------------------------
// sacd_set_ram
// Per-set state memory with one write and one registered read port. An
// epoch-free clearing pass is replaced by per-set valid bits (64 sets).
// ---------------------------------------------------------------------------
`default_nettype none

module sacd_set_ram
   import sacd_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                rd_en,
   input  wire logic [SET_BITS-1:0] rd_set,
   output set_type                  rd_data,
   input  wire logic                wr_en,
   input  wire logic [SET_BITS-1:0] wr_set,
   input  wire set_type             wr_data
);

   set_type             mem [SETS];
   set_type             rd_raw_ff;
   logic [SETS-1:0]     written_ff;
   logic                rd_written_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_set] <= wr_data;
      end
      if (rd_en) begin
         rd_raw_ff <= mem[rd_set];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff    <= '0;
         rd_written_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            written_ff[wr_set] <= 1'b1;
         end
         if (rd_en) begin
            rd_written_ff <= written_ff[rd_set];
         end
      end
   end

   assign rd_data = rd_written_ff ? rd_raw_ff : set_reset_value();

endmodule

`default_nettype wire

// ----- rtl/core/sacd_update.sv -----
// ---------------------------------------------------------------------------
// sacd_update
// Combinational set update: tag compare, victim selection and the new
// contents of the set for one operation.
// ---------------------------------------------------------------------------
`default_nettype none

module sacd_update
   import sacd_pkg::*;
(
   input  wire set_type              cur,
   input  wire logic [2:0]           func,
   input  wire logic [2:0]           policy,
   input  wire logic [TAG_BITS-1:0]  tag,
   input  wire logic [SET_BITS-1:0]  set_idx,
   input  wire logic                 dirty_in,
   output set_type                   nxt,
   output result_type                res
);

   logic [WAYS-1:0]     match;
   logic                hit;
   logic [WAY_BITS-1:0] hway;
   logic                has_free;
   logic [WAY_BITS-1:0] free_way;
   logic [WAY_BITS-1:0] victim;
   logic [WAY_BITS-1:0] ins_way;
   logic [WAY_BITS-1:0] plru_way;

   always_comb begin
      hit = 1'b0;
      hway = '0;
      has_free = 1'b0;
      free_way = '0;
      for (int k = WAYS - 1; k >= 0; k--) begin
         match[k] = cur.valid[k] && (cur.tag[k] == tag);
         if (match[k]) begin
            hit = 1'b1;
            hway = WAY_BITS'(k);
         end
         if (!cur.valid[k]) begin
            has_free = 1'b1;
            free_way = WAY_BITS'(k);
         end
      end
   end

   always_comb begin
      logic [COUNT_BITS-1:0] best;
      int unsigned node;
      best = '1;
      victim = '0;
      node = 0;
      for (int l = 0; l < WAY_BITS; l++) begin
         node = 2 * node + 1 + int'(cur.tree[node]);
      end
      plru_way = WAY_BITS'(node - (WAYS - 1));
      unique case (policy)
         POL_LFU: begin
            for (int k = 0; k < WAYS; k++) begin
               if (cur.count[k] <= best) begin
                  best = cur.count[k];
                  victim = WAY_BITS'(k);
               end
            end
         end
         POL_MFU: begin
            best = '0;
            for (int k = 0; k < WAYS; k++) begin
               if (cur.count[k] >= best) begin
                  best = cur.count[k];
                  victim = WAY_BITS'(k);
               end
            end
         end
         POL_LRU: begin
            victim = WAY_BITS'(WAYS - 1);
            for (int k = 0; k < WAYS; k++) begin
               if (cur.rank[k] == WAY_BITS'(WAYS - 1)) begin
                  victim = WAY_BITS'(k);
               end
            end
         end
         POL_PLRU: victim = plru_way;
         default:  victim = '0;
      endcase
   end

   assign ins_way = has_free ? free_way : victim;

   always_comb begin
      nxt = cur;
      res = '0;
      unique case (func)
         FUNC_INSERT: begin
            res.hit = hit;
            res.way = ins_way;
            if (!has_free) begin
               res.victim_valid   = 1'b1;
               res.victim_dirty   = cur.dirty[victim];
               res.victim_address = {cur.tag[victim], set_idx, OFF_BITS'(0)};
            end
            nxt.valid[ins_way] = 1'b1;
            nxt.tag[ins_way]   = tag;
            nxt.dirty[ins_way] = dirty_in;
            nxt.count[ins_way] = '0;
            nxt = touch(nxt, ins_way);
         end
         FUNC_LOOKUP, FUNC_PROBE, FUNC_WRITE, FUNC_WCOUNT, FUNC_REFRESH: begin
            res.hit = hit;
            res.way = hway;
            if (func == FUNC_LOOKUP && hit) begin
               if (cur.count[hway] != COUNT_MAX) begin
                  nxt.count[hway] = cur.count[hway] + 1'b1;
               end
               nxt = touch(nxt, hway);
            end
            for (int k = 0; k < WAYS; k++) begin
               if (match[k]) begin
                  if (func == FUNC_WCOUNT) begin
                     if (cur.count[k] != COUNT_MAX) begin
                        nxt.count[k] = cur.count[k] + 1'b1;
                     end
                  end else if (func == FUNC_WRITE || func == FUNC_REFRESH) begin
                     nxt.dirty[k] = dirty_in;
                     if (func == FUNC_WRITE) begin
                        nxt = touch(nxt, WAY_BITS'(k));
                     end
                  end
               end
            end
         end
         default: begin
            nxt = cur;
         end
      endcase
   end

endmodule

`default_nettype wire
